// ===== src/aids_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aids_pkg: shared types and constants for the array insert/delete/search block
// Operation and status codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package aids_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int OP_W         = 3;
   localparam int POS_W        = 7;
   localparam int VAL_W        = 32;
   localparam int STS_W        = 3;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT  = 3'd0,
      OP_DELETE  = 3'd1,
      OP_REVERSE = 3'd2,
      OP_SEARCH  = 3'd3,
      OP_DUMP    = 3'd4
   } op_type;

   typedef enum logic [STS_W-1:0] {
      STS_OK        = 3'd0,
      STS_NOT_FOUND = 3'd1,
      STS_FULL      = 3'd2,
      STS_BAD_POS   = 3'd3,
      STS_EMPTY     = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_INS_PUT,
      ST_REV_RD_LO,
      ST_REV_RD_HI,
      ST_REV_WR_LO,
      ST_REV_WR_HI,
      ST_SEARCH,
      ST_DUMP,
      ST_FINISH
   } state_type;

   // memory write data source
   typedef enum logic [1:0] {
      WSRC_RDATA,
      WSRC_HOLD,
      WSRC_KEY
   } wsrc_type;

   // result value source
   typedef enum logic [1:0] {
      VSEL_ZERO,
      VSEL_RDATA,
      VSEL_HOLD
   } vsel_type;

   typedef struct packed {
      logic             rd_en;
      logic             wr_en;
      wsrc_type         wr_src;
      logic             hold_en;
      logic             key_load;
      logic             out_load;
      status_type       out_status;
      vsel_type         out_vsel;
      logic [POS_W-1:0] out_pos;
      logic             out_last;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic match;
   } sts_type;

endpackage

// ===== src/aids_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aids_req_if / aids_rsp_if: request and response channels
// Valid/ready channels; a transaction completes when valid and ready are high.
// ----------------------------------------------------------------------------
interface aids_req_if;
   import aids_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [OP_W-1:0]         operation;
   logic [POS_W-1:0]        position;
   logic signed [VAL_W-1:0] value;

   modport source (output valid, operation, position, value, input ready);
   modport sink   (input valid, operation, position, value, output ready);
endinterface

interface aids_rsp_if;
   import aids_pkg::*;

   logic                    valid;
   logic                    ready;
   logic [STS_W-1:0]        status;
   logic signed [VAL_W-1:0] value_res;
   logic [POS_W-1:0]        position_res;
   logic                    last;

   modport source (output valid, status, value_res, position_res, last, input ready);
   modport sink   (input valid, status, value_res, position_res, last, output ready);
endinterface

// ===== src/aids_dpath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aids_dpath: entry memory, holding registers and response register
// Simple dual-port entry RAM (one write, one registered read per cycle),
// key compare and the output register of the response channel.
// ----------------------------------------------------------------------------
module aids_dpath #(
   parameter int CAPACITY = aids_pkg::CAPACITY_DEF,
   localparam int ADDR_W  = $clog2(CAPACITY)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  aids_pkg::cmd_type                cmd,
   input  logic [ADDR_W-1:0]                rd_addr,
   input  logic [ADDR_W-1:0]                wr_addr,
   input  logic signed [aids_pkg::VAL_W-1:0] key,
   output aids_pkg::sts_type                sts,
   aids_rsp_if.source                       rsp_ch
);
   import aids_pkg::*;

   logic [VAL_W-1:0] mem [CAPACITY];
   logic [VAL_W-1:0] rd_data_ff;
   logic [VAL_W-1:0] hold_ff;
   logic [VAL_W-1:0] key_ff;
   logic [VAL_W-1:0] wr_data;
   logic [VAL_W-1:0] out_value;

   logic             rsp_valid_ff;
   logic [STS_W-1:0] rsp_status_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic [POS_W-1:0] rsp_pos_ff;
   logic             rsp_last_ff;

   always_comb begin
      case (cmd.wr_src)
         WSRC_RDATA: wr_data = rd_data_ff;
         WSRC_HOLD:  wr_data = hold_ff;
         WSRC_KEY:   wr_data = key_ff;
         default:    wr_data = rd_data_ff;
      endcase
   end

   always_comb begin
      case (cmd.out_vsel)
         VSEL_RDATA: out_value = rd_data_ff;
         VSEL_HOLD:  out_value = hold_ff;
         default:    out_value = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_en) begin
         hold_ff <= rd_data_ff;
      end
      if (cmd.key_load) begin
         key_ff <= key;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_status_ff <= cmd.out_status;
         rsp_value_ff  <= out_value;
         rsp_pos_ff    <= cmd.out_pos;
         rsp_last_ff   <= cmd.out_last;
      end
   end

   assign sts.out_free        = !rsp_valid_ff || rsp_ch.ready;
   assign sts.match           = (rd_data_ff == key_ff);

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.status       = rsp_status_ff;
   assign rsp_ch.value_res    = rsp_value_ff;
   assign rsp_ch.position_res = rsp_pos_ff;
   assign rsp_ch.last         = rsp_last_ff;

endmodule

// ===== src/aids_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aids_ctrl: operation sequencer
// Decodes each request, keeps the entry count and walks the memory pointers
// for shift, reverse, search and dump; issues commands to the datapath.
// ----------------------------------------------------------------------------
module aids_ctrl #(
   parameter int CAPACITY = aids_pkg::CAPACITY_DEF,
   localparam int ADDR_W  = $clog2(CAPACITY)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [aids_pkg::OP_W-1:0]    req_operation,
   input  logic [aids_pkg::POS_W-1:0]   req_position,
   output aids_pkg::cmd_type            cmd,
   output logic [ADDR_W-1:0]            rd_addr,
   output logic [ADDR_W-1:0]            wr_addr,
   input  aids_pkg::sts_type            sts
);
   import aids_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [ADDR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] stop_ptr_ff, stop_ptr_in;
   logic              rd_act_ff, rd_act_in;
   logic              pend_ff, pend_in;
   logic              first_ff, first_in;
   logic              dir_up_ff, dir_up_in;
   status_type        res_status_ff, res_status_in;
   vsel_type          res_vsel_ff, res_vsel_in;
   logic [POS_W-1:0]  res_pos_ff, res_pos_in;

   logic [CMP_W-1:0]  pos_ext;
   logic [CMP_W-1:0]  count_ext;
   logic [ADDR_W-1:0] p_idx;
   logic              full;
   logic              ins_ok;
   logic              del_ok;
   logic              rev_more;

   assign pos_ext   = CMP_W'(req_position);
   assign count_ext = CMP_W'(count_ff);
   assign p_idx     = ADDR_W'(pos_ext - 1'b1);
   assign full      = (count_ff == CNT_W'(CAPACITY));
   assign ins_ok    = (req_position != '0) && (pos_ext <= count_ext + 1'b1);
   assign del_ok    = (req_position != '0) && (pos_ext <= count_ext);
   // another pair remains after the current lo/hi swap
   assign rev_more  = ({1'b0, rd_ptr_ff} + 2'd2) < {1'b0, wr_ptr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         rd_act_ff <= 1'b0;
         pend_ff   <= 1'b0;
         first_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rd_act_ff <= rd_act_in;
         pend_ff   <= pend_in;
         first_ff  <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff     <= rd_ptr_in;
      wr_ptr_ff     <= wr_ptr_in;
      stop_ptr_ff   <= stop_ptr_in;
      dir_up_ff     <= dir_up_in;
      res_status_ff <= res_status_in;
      res_vsel_ff   <= res_vsel_in;
      res_pos_ff    <= res_pos_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      wr_ptr_in     = wr_ptr_ff;
      stop_ptr_in   = stop_ptr_ff;
      rd_act_in     = rd_act_ff;
      pend_in       = pend_ff;
      first_in      = first_ff;
      dir_up_in     = dir_up_ff;
      res_status_in = res_status_ff;
      res_vsel_in   = res_vsel_ff;
      res_pos_in    = res_pos_ff;
      cmd           = '0;
      rd_addr       = rd_ptr_ff;
      wr_addr       = wr_ptr_ff;
      req_ready     = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.key_load  = 1'b1;
               res_status_in = STS_OK;
               res_vsel_in   = VSEL_ZERO;
               res_pos_in    = '0;
               case (req_operation)
                  OP_INSERT: begin
                     if (full) begin
                        res_status_in = STS_FULL;
                        state_in      = ST_FINISH;
                     end else if (!ins_ok) begin
                        res_status_in = STS_BAD_POS;
                        state_in      = ST_FINISH;
                     end else begin
                        res_pos_in  = req_position;
                        stop_ptr_in = p_idx;
                        if (pos_ext == count_ext + 1'b1) begin
                           state_in = ST_INS_PUT;
                        end else begin
                           rd_ptr_in = ADDR_W'(count_ff - 1'b1);
                           wr_ptr_in = ADDR_W'(count_ff);
                           rd_act_in = 1'b1;
                           pend_in   = 1'b0;
                           first_in  = 1'b0;
                           dir_up_in = 1'b1;
                           state_in  = ST_SHIFT;
                        end
                     end
                  end
                  OP_DELETE: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        state_in      = ST_FINISH;
                     end else if (!del_ok) begin
                        res_status_in = STS_BAD_POS;
                        state_in      = ST_FINISH;
                     end else begin
                        res_pos_in  = req_position;
                        res_vsel_in = VSEL_HOLD;
                        rd_ptr_in   = p_idx;
                        wr_ptr_in   = p_idx;
                        stop_ptr_in = ADDR_W'(count_ff - 1'b1);
                        rd_act_in   = 1'b1;
                        pend_in     = 1'b0;
                        first_in    = 1'b1;
                        dir_up_in   = 1'b0;
                        state_in    = ST_SHIFT;
                     end
                  end
                  OP_REVERSE: begin
                     if (count_ff < CNT_W'(2)) begin
                        state_in = ST_FINISH;
                     end else begin
                        rd_ptr_in = '0;
                        wr_ptr_in = ADDR_W'(count_ff - 1'b1);
                        state_in  = ST_REV_RD_LO;
                     end
                  end
                  OP_SEARCH: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_NOT_FOUND;
                        state_in      = ST_FINISH;
                     end else begin
                        rd_ptr_in   = '0;
                        wr_ptr_in   = '0;
                        stop_ptr_in = ADDR_W'(count_ff - 1'b1);
                        rd_act_in   = 1'b1;
                        pend_in     = 1'b0;
                        state_in    = ST_SEARCH;
                     end
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        res_status_in = STS_EMPTY;
                        state_in      = ST_FINISH;
                     end else begin
                        cmd.rd_en   = 1'b1;
                        rd_addr     = '0;
                        rd_ptr_in   = '0;
                        stop_ptr_in = ADDR_W'(count_ff - 1'b1);
                        state_in    = ST_DUMP;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end

         // streamed move: read one entry ahead, write it one slot over
         ST_SHIFT: begin
            if (pend_ff) begin
               if (first_ff) begin
                  cmd.hold_en = 1'b1;   // removed entry on delete
                  first_in    = 1'b0;
               end else begin
                  cmd.wr_en  = 1'b1;
                  cmd.wr_src = WSRC_RDATA;
                  wr_addr    = wr_ptr_ff;
                  wr_ptr_in  = dir_up_ff ? wr_ptr_ff - 1'b1 : wr_ptr_ff + 1'b1;
               end
            end
            if (rd_act_ff) begin
               cmd.rd_en = 1'b1;
               rd_addr   = rd_ptr_ff;
               pend_in   = 1'b1;
               if (rd_ptr_ff == stop_ptr_ff) begin
                  rd_act_in = 1'b0;
               end else begin
                  rd_ptr_in = dir_up_ff ? rd_ptr_ff - 1'b1 : rd_ptr_ff + 1'b1;
               end
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && !rd_act_ff) begin
               if (dir_up_ff) begin
                  state_in = ST_INS_PUT;
               end else begin
                  count_in = count_ff - 1'b1;
                  state_in = ST_FINISH;
               end
            end
         end

         ST_INS_PUT: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_KEY;
            wr_addr    = stop_ptr_ff;
            count_in   = count_ff + 1'b1;
            state_in   = ST_FINISH;
         end

         ST_REV_RD_LO: begin
            cmd.rd_en = 1'b1;
            rd_addr   = rd_ptr_ff;
            state_in  = ST_REV_RD_HI;
         end

         ST_REV_RD_HI: begin
            cmd.hold_en = 1'b1;
            cmd.rd_en   = 1'b1;
            rd_addr     = wr_ptr_ff;
            state_in    = ST_REV_WR_LO;
         end

         ST_REV_WR_LO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_RDATA;
            wr_addr    = rd_ptr_ff;
            if (rev_more) begin
               cmd.rd_en = 1'b1;
               rd_addr   = rd_ptr_ff + 1'b1;
            end
            state_in = ST_REV_WR_HI;
         end

         ST_REV_WR_HI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_src = WSRC_HOLD;
            wr_addr    = wr_ptr_ff;
            rd_ptr_in  = rd_ptr_ff + 1'b1;
            wr_ptr_in  = wr_ptr_ff - 1'b1;
            if (rev_more) begin
               cmd.hold_en = 1'b1;
               cmd.rd_en   = 1'b1;
               rd_addr     = wr_ptr_ff - 1'b1;
               state_in    = ST_REV_WR_LO;
            end else begin
               state_in = ST_FINISH;
            end
         end

         // wr_ptr trails rd_ptr as the index of the entry being compared
         ST_SEARCH: begin
            if (pend_ff && sts.match) begin
               res_pos_in = POS_W'({1'b0, wr_ptr_ff} + 1'b1);
               pend_in    = 1'b0;
               rd_act_in  = 1'b0;
               state_in   = ST_FINISH;
            end else if (pend_ff && !rd_act_ff) begin
               res_status_in = STS_NOT_FOUND;
               pend_in       = 1'b0;
               state_in      = ST_FINISH;
            end else begin
               if (pend_ff) begin
                  wr_ptr_in = wr_ptr_ff + 1'b1;
               end
               if (rd_act_ff) begin
                  cmd.rd_en = 1'b1;
                  rd_addr   = rd_ptr_ff;
                  pend_in   = 1'b1;
                  if (rd_ptr_ff == stop_ptr_ff) begin
                     rd_act_in = 1'b0;
                  end else begin
                     rd_ptr_in = rd_ptr_ff + 1'b1;
                  end
               end
            end
         end

         ST_DUMP: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = STS_OK;
               cmd.out_vsel   = VSEL_RDATA;
               cmd.out_pos    = POS_W'({1'b0, rd_ptr_ff} + 1'b1);
               cmd.out_last   = (rd_ptr_ff == stop_ptr_ff);
               if (rd_ptr_ff == stop_ptr_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  cmd.rd_en = 1'b1;
                  rd_addr   = rd_ptr_ff + 1'b1;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            if (sts.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_status = res_status_ff;
               cmd.out_vsel   = res_vsel_ff;
               cmd.out_pos    = res_pos_ff;
               cmd.out_last   = 1'b1;
               state_in       = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

`ifndef SYNTH
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count above capacity");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      !$stable(count_ff) |->
         (count_ff == $past(count_ff) + 1'b1) || (count_ff == $past(count_ff) - 1'b1))
      else $error("entry count moved by more than one");

   a_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> sts.out_free)
      else $error("response register loaded while occupied");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (cmd.rd_en && cmd.wr_en) |-> (rd_addr != wr_addr))
      else $error("read and write to the same entry in one cycle");
`endif

endmodule

// ===== src/array_insert_delete_search_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// array_insert_delete_search_top: ordered array with insert/delete/search
// Keeps up to CAPACITY signed 32-bit entries and a count; each request
// performs insert, delete, reverse, search or dump on the array.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one request per transaction (operation, position, value).
//   rsp_ch returns the results; every operation gives one response with last
//   set, except dump, which gives one response per entry (last on the final
//   one) or a single empty response. Codes 5 to 7 are taken and give nothing.
//   Requests are taken one at a time; req_ch.ready is high only between them,
//   and a finished response may still wait in the output register.
//   Each request walks the entry RAM: insert moves the entries from the
//   1-based position p up one slot and then writes the value, delete holds
//   the removed entry and moves the later entries down, reverse swaps pairs
//   from both ends with a low write and a high write per pair, search reads
//   from the first entry up to a hit or the last entry, and dump gives one
//   response a cycle while the receiver is ready. The entry RAM takes one read and one write each cycle.
//   A stalled receiver holds the output register; the block then waits.
//   Reset empties the array at once (count to zero, no clearing pass) and
//   drops any pending response.
// ----------------------------------------------------------------------------
module array_insert_delete_search_top #(
   parameter int CAPACITY = aids_pkg::CAPACITY_DEF
) (
   input  logic       clock,
   input  logic       reset,
   aids_req_if.sink   req_ch,
   aids_rsp_if.source rsp_ch
);
   import aids_pkg::*;

   localparam int ADDR_W = $clog2(CAPACITY);

   cmd_type           cmd;
   sts_type           sts;
   logic [ADDR_W-1:0] rd_addr;
   logic [ADDR_W-1:0] wr_addr;

   aids_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_ch.valid),
      .req_ready     (req_ch.ready),
      .req_operation (req_ch.operation),
      .req_position  (req_ch.position),
      .cmd           (cmd),
      .rd_addr       (rd_addr),
      .wr_addr       (wr_addr),
      .sts           (sts)
   );

   aids_dpath #(
      .CAPACITY (CAPACITY)
   ) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .rd_addr (rd_addr),
      .wr_addr (wr_addr),
      .key     (req_ch.value),
      .sts     (sts),
      .rsp_ch  (rsp_ch)
   );

endmodule
